[src/rpfe_pkg.sv]
// Shared types and constants for the raster primitive fill engine.
// Holds the command and sequencer state codes and the coordinate helpers.
// No dependencies.
`default_nettype none

package rpfe_pkg;

    localparam int CMD_W   = 3;
    localparam int COORD_W = 8;
    localparam int EXT_W   = 7;
    localparam int BITS_W  = 64;
    localparam int SPAN_W  = 10;
    localparam int SQ_W    = 16;

    localparam logic signed [SPAN_W-1:0] SPAN_ZERO = '0;
    localparam logic signed [SPAN_W-1:0] SPAN_ONE  = SPAN_W'(1);

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR = 3'd0,
        CMD_FILL  = 3'd1,
        CMD_LINE  = 3'd2,
        CMD_DISK  = 3'd3,
        CMD_TRI   = 3'd4,
        CMD_ERASE = 3'd5,
        CMD_READ  = 3'd6
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LIM,
        ST_DYSQ,
        ST_FIT,
        ST_READ,
        ST_WRITE,
        ST_CAPTURE,
        ST_DONE
    } state_t;

    function automatic logic signed [SPAN_W-1:0] sext_coord(input logic [COORD_W-1:0] v);
        sext_coord = {{(SPAN_W-COORD_W){v[COORD_W-1]}}, v};
    endfunction

    function automatic logic signed [SPAN_W-1:0] zext_ext(input logic [EXT_W-1:0] v);
        zext_ext = {{(SPAN_W-EXT_W){1'b0}}, v};
    endfunction

endpackage

`default_nettype wire

[src/raster_primitive_fill_engine_top.sv]
// Path to res_valid: clear, unknown command and off-canvas read go straight to DONE; read row
// goes READ, CAPTURE, DONE. Fill, erase, line and triangle do READ, WRITE per clipped row (RMW).
// Disk uses the shared squarer in LIM, DYSQ, then per row FIT (radius tracking), READ, WRITE.
// One command at a time; cmd_stall falls as the result loads.
// Reset clears per-row valid flags, so the whole canvas reads blank at once: no clearing pass.
// Depends on rpfe_pkg, rpfe_ram, rpfe_mask.
`default_nettype none

module raster_primitive_fill_engine_top #(
    parameter int CANVAS_COLS = 64,
    parameter int CANVAS_ROWS = 32
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cmd_valid,
    output      logic                                cmd_stall,
    input  wire logic [rpfe_pkg::CMD_W-1:0]          command,
    input  wire logic signed [rpfe_pkg::COORD_W-1:0] col,
    input  wire logic signed [rpfe_pkg::COORD_W-1:0] row,
    input  wire logic [rpfe_pkg::EXT_W-1:0]          extent_w,
    input  wire logic [rpfe_pkg::EXT_W-1:0]          extent_h,
    input  wire logic signed [rpfe_pkg::COORD_W-1:0] end_col,
    input  wire logic signed [rpfe_pkg::COORD_W-1:0] end_row,
    input  wire logic [rpfe_pkg::EXT_W-1:0]          radius,
    output      logic                                res_valid,
    input  wire logic                                res_stall,
    output      logic [rpfe_pkg::BITS_W-1:0]         row_bits,
    output      logic                                status
);

    import rpfe_pkg::*;

    localparam int ROW_W = (CANVAS_ROWS > 1) ? $clog2(CANVAS_ROWS) : 1;
    localparam logic signed [SPAN_W-1:0] ROW_MAX = SPAN_W'(CANVAS_ROWS - 1);

    state_t                    state_reg, state_next;
    cmd_t                      cmd_reg, cmd_next;
    logic signed [SPAN_W-1:0]  c_reg, c_next;
    logic signed [SPAN_W-1:0]  r_reg, r_next;
    logic signed [SPAN_W-1:0]  span_lo_reg, span_lo_next;
    logic signed [SPAN_W-1:0]  span_hi_reg, span_hi_next;
    logic [EXT_W-1:0]          radius_reg, radius_next;
    logic [ROW_W-1:0]          row_cur_reg, row_cur_next;
    logic [ROW_W-1:0]          row_last_reg, row_last_next;
    logic signed [SPAN_W-1:0]  dy_reg, dy_next;
    logic [SQ_W-1:0]           dysq_reg, dysq_next;
    logic [SQ_W-1:0]           lim_reg, lim_next;
    logic [EXT_W-1:0]          w_reg, w_next;
    logic [SQ_W-1:0]           wsq_reg, wsq_next;
    logic [CANVAS_ROWS-1:0]    valid_reg, valid_next;
    logic [CANVAS_COLS-1:0]    pend_bits_reg, pend_bits_next;
    logic                      pend_status_reg, pend_status_next;
    logic                      res_valid_reg, res_valid_next;
    logic [BITS_W-1:0]         res_bits_reg, res_bits_next;
    logic                      res_status_reg, res_status_next;

    cmd_t                      cmd_in;
    logic signed [SPAN_W-1:0]  c_in, r_in, w_in, h_in, ec_in, er_in, rad_in;
    logic signed [SPAN_W-1:0]  rlo, rhi, slo, shi, lo_c, hi_c;
    logic                      any_rows, rows_ok, cmd_accept;

    logic signed [SPAN_W-1:0]  dy_mag, row_ext, w_ext, mlo, mhi;
    logic [EXT_W-1:0]          sq_op;
    logic [SQ_W-1:0]           sq, tot0, tot1, two_w1;
    logic                      fit_dec, fit_inc;

    logic [CANVAS_COLS-1:0]    mask, old_bits, new_bits, rd_data;
    logic                      ram_wr_en, ram_rd_en;

    assign cmd_in     = cmd_t'(command);
    assign c_in       = sext_coord(col);
    assign r_in       = sext_coord(row);
    assign ec_in      = sext_coord(end_col);
    assign er_in      = sext_coord(end_row);
    assign w_in       = zext_ext(extent_w);
    assign h_in       = zext_ext(extent_h);
    assign rad_in     = zext_ext(radius);
    assign cmd_stall  = (state_reg != ST_IDLE);
    assign cmd_accept = cmd_valid && !cmd_stall;

    always_comb
    begin
        rlo      = r_in;
        rhi      = r_in;
        slo      = c_in;
        shi      = c_in;
        any_rows = 1'b1;
        case (cmd_in)
            CMD_FILL, CMD_ERASE:
            begin
                rhi = r_in + h_in - SPAN_ONE;
                shi = c_in + w_in - SPAN_ONE;
            end
            CMD_LINE:
            begin
                if (r_in == er_in)
                begin
                    shi = ec_in;
                end
                else if (c_in == ec_in)
                begin
                    rhi = er_in;
                end
                else
                begin
                    any_rows = 1'b0;
                end
            end
            CMD_DISK:
            begin
                rlo = r_in - rad_in;
                rhi = r_in + rad_in;
            end
            CMD_TRI:
            begin
                rhi = r_in + w_in - SPAN_ONE;
            end
            default:
            begin
                rlo = r_in;
            end
        endcase
        lo_c    = (rlo < SPAN_ZERO) ? SPAN_ZERO : rlo;
        hi_c    = (rhi > ROW_MAX) ? ROW_MAX : rhi;
        rows_ok = any_rows && (lo_c <= hi_c);
    end

    assign dy_mag = dy_reg[SPAN_W-1] ? -dy_reg : dy_reg;
    assign sq_op  = (state_reg == ST_LIM) ? radius_reg : dy_mag[EXT_W-1:0];
    assign sq     = SQ_W'(sq_op) * SQ_W'(sq_op);
    assign two_w1 = {{(SQ_W-EXT_W-1){1'b0}}, w_reg, 1'b1};
    assign tot0   = wsq_reg + dysq_reg;
    assign tot1   = tot0 + two_w1;
    assign fit_dec = (tot0 > lim_reg);
    assign fit_inc = (w_reg < radius_reg) && (tot1 <= lim_reg);

    assign row_ext = SPAN_W'(row_cur_reg);
    assign w_ext   = zext_ext(w_reg);

    always_comb
    begin
        case (cmd_reg)
            CMD_DISK:
            begin
                mlo = c_reg - w_ext;
                mhi = c_reg + w_ext;
            end
            CMD_TRI:
            begin
                mlo = c_reg;
                mhi = c_reg + (row_ext - r_reg);
            end
            default:
            begin
                mlo = span_lo_reg;
                mhi = span_hi_reg;
            end
        endcase
    end

    rpfe_mask #(.COLS(CANVAS_COLS)) u_mask (
        .lo   (mlo),
        .hi   (mhi),
        .mask (mask)
    );

    assign old_bits = valid_reg[row_cur_reg] ? rd_data : '0;
    assign new_bits = (cmd_reg == CMD_ERASE) ? (old_bits & ~mask) : (old_bits | mask);

    rpfe_ram #(.WIDTH(CANVAS_COLS), .DEPTH(CANVAS_ROWS)) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (row_cur_reg),
        .wr_data (new_bits),
        .rd_en   (ram_rd_en),
        .rd_addr (row_cur_reg),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        c_next           = c_reg;
        r_next           = r_reg;
        span_lo_next     = span_lo_reg;
        span_hi_next     = span_hi_reg;
        radius_next      = radius_reg;
        row_cur_next     = row_cur_reg;
        row_last_next    = row_last_reg;
        dy_next          = dy_reg;
        dysq_next        = dysq_reg;
        lim_next         = lim_reg;
        w_next           = w_reg;
        wsq_next         = wsq_reg;
        valid_next       = valid_reg;
        pend_bits_next   = pend_bits_reg;
        pend_status_next = pend_status_reg;
        res_valid_next   = res_valid_reg;
        res_bits_next    = res_bits_reg;
        res_status_next  = res_status_reg;
        ram_wr_en        = 1'b0;
        ram_rd_en        = 1'b0;

        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next         = cmd_in;
                    c_next           = c_in;
                    r_next           = r_in;
                    span_lo_next     = slo;
                    span_hi_next     = shi;
                    radius_next      = radius;
                    row_cur_next     = lo_c[ROW_W-1:0];
                    row_last_next    = hi_c[ROW_W-1:0];
                    dy_next          = lo_c - r_in;
                    w_next           = '0;
                    wsq_next         = '0;
                    pend_bits_next   = '0;
                    pend_status_next = 1'b0;
                    state_next       = ST_DONE;
                    case (cmd_in)
                        CMD_CLEAR:
                        begin
                            valid_next = '0;
                        end
                        CMD_READ:
                        begin
                            if (rows_ok)
                            begin
                                state_next = ST_READ;
                            end
                            else
                            begin
                                pend_status_next = 1'b1;
                            end
                        end
                        CMD_DISK:
                        begin
                            if (rows_ok)
                            begin
                                state_next = ST_LIM;
                            end
                        end
                        CMD_FILL, CMD_ERASE, CMD_LINE, CMD_TRI:
                        begin
                            if (rows_ok)
                            begin
                                state_next = ST_READ;
                            end
                        end
                        default:
                        begin
                            pend_status_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_LIM:
            begin
                lim_next   = sq;
                state_next = ST_DYSQ;
            end
            ST_DYSQ:
            begin
                dysq_next  = sq;
                state_next = ST_FIT;
            end
            ST_FIT:
            begin
                if (fit_dec)
                begin
                    w_next   = w_reg - EXT_W'(1);
                    wsq_next = wsq_reg - {{(SQ_W-EXT_W-1){1'b0}}, w_reg, 1'b0} + SQ_W'(1);
                end
                else if (fit_inc)
                begin
                    w_next   = w_reg + EXT_W'(1);
                    wsq_next = wsq_reg + two_w1;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                ram_rd_en  = 1'b1;
                state_next = (cmd_reg == CMD_READ) ? ST_CAPTURE : ST_WRITE;
            end
            ST_CAPTURE:
            begin
                pend_bits_next = old_bits;
                state_next     = ST_DONE;
            end
            ST_WRITE:
            begin
                ram_wr_en               = 1'b1;
                valid_next[row_cur_reg] = 1'b1;
                if (row_cur_reg == row_last_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    row_cur_next = row_cur_reg + ROW_W'(1);
                    dy_next      = dy_reg + SPAN_ONE;
                    dysq_next    = dysq_reg
                                 + {{(SQ_W-SPAN_W-1){dy_reg[SPAN_W-1]}}, dy_reg, 1'b1};
                    state_next   = (cmd_reg == CMD_DISK) ? ST_FIT : ST_READ;
                end
            end
            ST_DONE:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_valid_next  = 1'b1;
                    res_bits_next   = BITS_W'(pend_bits_reg);
                    res_status_next = pend_status_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        c_reg           <= c_next;
        r_reg           <= r_next;
        span_lo_reg     <= span_lo_next;
        span_hi_reg     <= span_hi_next;
        radius_reg      <= radius_next;
        row_cur_reg     <= row_cur_next;
        row_last_reg    <= row_last_next;
        dy_reg          <= dy_next;
        dysq_reg        <= dysq_next;
        lim_reg         <= lim_next;
        w_reg           <= w_next;
        wsq_reg         <= wsq_next;
        pend_bits_reg   <= pend_bits_next;
        pend_status_reg <= pend_status_next;
        res_bits_reg    <= res_bits_next;
        res_status_reg  <= res_status_next;
    end

    assign res_valid = res_valid_reg;
    assign row_bits  = res_bits_reg;
    assign status    = res_status_reg;

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> (row_cur_reg <= row_last_reg))
        else $error("row write past last row of the sweep");

    a_clear_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_accept && (cmd_in == CMD_CLEAR)) |=> (valid_reg == '0))
        else $error("clear did not blank the canvas");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result loaded outside the done state");

    a_disk_width: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_WRITE) && (cmd_reg == CMD_DISK)) |-> (w_reg <= radius_reg))
        else $error("disk half-width exceeds radius");

    a_idle_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DONE) && !res_stall) |=> (state_reg == ST_IDLE) && res_valid_reg)
        else $error("done state did not hand off its transaction");

endmodule

`default_nettype wire

[src/rpfe_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Used for the canvas row store. No dependencies.
`default_nettype none

module rpfe_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  wire logic                             clk,
    input  wire logic                             wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]         wr_addr,
    input  wire logic [WIDTH-1:0]                 wr_data,
    input  wire logic                             rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]         rd_addr,
    output      logic [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[src/rpfe_mask.sv]
// Column span mask: sets every canvas column between lo and hi inclusive.
// Clips to the canvas implicitly. Depends on rpfe_pkg.
`default_nettype none

module rpfe_mask #(
    parameter int COLS = 64
) (
    input  wire logic signed [rpfe_pkg::SPAN_W-1:0] lo,
    input  wire logic signed [rpfe_pkg::SPAN_W-1:0] hi,
    output      logic [COLS-1:0]                    mask
);

    import rpfe_pkg::*;

    for (genvar j = 0; j < COLS; j++)
    begin : g_col
        localparam logic signed [SPAN_W-1:0] JV = SPAN_W'(j);
        assign mask[j] = (JV >= lo) && (JV <= hi);
    end

endmodule

`default_nettype wire

[test/raster_primitive_fill_engine_top_test.sv]
`timescale 1ns / 100ps
// Testbench for raster_primitive_fill_engine_top: directed and random drawing commands
// checked against a shadow canvas kept here. Needs rpfe_pkg and the engine RTL only.

module raster_primitive_fill_engine_top_test;

    import rpfe_pkg::*;

    localparam int COLS = 64;
    localparam int ROWS = 32;
    localparam int N_RANDOM = 2000;
    localparam int MAX_SHOWN = 10;
    localparam int TAIL_CYCLES = 400;
    localparam logic [CMD_W-1:0] CMD_UNKNOWN = 3'd7;

    typedef struct {
        logic [CMD_W-1:0]         op;
        logic signed [COORD_W-1:0] c;
        logic signed [COORD_W-1:0] r;
        logic [EXT_W-1:0]         w;
        logic [EXT_W-1:0]         h;
        logic signed [COORD_W-1:0] ec;
        logic signed [COORD_W-1:0] er;
        logic [EXT_W-1:0]         rad;
        int unsigned              idle;
    } draw_cmd_t;

    typedef struct {
        logic [CMD_W-1:0]  op;
        logic [BITS_W-1:0] bits;
        logic              flag;
    } row_reply_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cmd_valid;
    logic                      cmd_stall;
    logic [CMD_W-1:0]          command;
    logic signed [COORD_W-1:0] col;
    logic signed [COORD_W-1:0] row;
    logic [EXT_W-1:0]          extent_w;
    logic [EXT_W-1:0]          extent_h;
    logic signed [COORD_W-1:0] end_col;
    logic signed [COORD_W-1:0] end_row;
    logic [EXT_W-1:0]          radius;
    logic                      res_valid;
    logic                      res_stall;
    logic [BITS_W-1:0]         row_bits;
    logic                      status;

    draw_cmd_t   pending_cmds[$];
    row_reply_t  expected_replies[$];
    logic [COLS-1:0] shadow_rows[ROWS];

    logic        cmd_fire;
    logic        res_fire;
    logic        hold_off;
    int unsigned cmd_idle;
    int unsigned res_idle;
    int unsigned replies_seen;
    int unsigned flagged_seen;
    int unsigned mismatches;
    int unsigned op_count[8];

    raster_primitive_fill_engine_top #(
        .CANVAS_COLS (COLS),
        .CANVAS_ROWS (ROWS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .command   (command),
        .col       (col),
        .row       (row),
        .extent_w  (extent_w),
        .extent_h  (extent_h),
        .end_col   (end_col),
        .end_row   (end_row),
        .radius    (radius),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .row_bits  (row_bits),
        .status    (status)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic logic [COLS-1:0] span_bits(int lo, int hi);
        logic [COLS-1:0] m;
        m = '0;
        if (lo < 0)
            lo = 0;
        if (hi > COLS - 1)
            hi = COLS - 1;
        for (int k = lo; k <= hi; k++)
            m[k] = 1'b1;
        return m;
    endfunction

    task automatic paint_band(int r0, int r1, logic [COLS-1:0] mask, logic set);
        if (r0 < 0)
            r0 = 0;
        if (r1 > ROWS - 1)
            r1 = ROWS - 1;
        for (int i = r0; i <= r1; i++)
            shadow_rows[i] = set ? (shadow_rows[i] | mask) : (shadow_rows[i] & ~mask);
    endtask

    task automatic render_command(input draw_cmd_t t, output row_reply_t o);
        int c, r, ec, er, w, h, rad, lim, dx, dy, y;
        c   = t.c;
        r   = t.r;
        ec  = t.ec;
        er  = t.er;
        w   = int'(t.w);
        h   = int'(t.h);
        rad = int'(t.rad);
        o.op   = t.op;
        o.bits = '0;
        o.flag = 1'b0;
        op_count[t.op]++;
        case (t.op)
            CMD_CLEAR:
                for (int i = 0; i < ROWS; i++)
                    shadow_rows[i] = '0;
            CMD_FILL, CMD_ERASE:
                if (w > 0 && h > 0)
                    paint_band(r, r + h - 1, span_bits(c, c + w - 1), t.op == CMD_FILL);
            CMD_LINE:
                if (r == er)
                begin
                    if (ec >= c)
                        paint_band(r, r, span_bits(c, ec), 1'b1);
                end
                else if (c == ec)
                begin
                    if (er >= r)
                        paint_band(r, er, span_bits(c, c), 1'b1);
                end
            CMD_DISK:
            begin
                lim = rad * rad;
                for (int i = 0; i < ROWS; i++)
                begin
                    dy = i - r;
                    for (int j = 0; j < COLS; j++)
                    begin
                        dx = j - c;
                        if (dx * dx + dy * dy <= lim)
                            shadow_rows[i][j] = 1'b1;
                    end
                end
            end
            CMD_TRI:
                for (int i = 0; i < w; i++)
                begin
                    y = r + i;
                    if (y >= 0 && y < ROWS)
                        shadow_rows[y] = shadow_rows[y] | span_bits(c, c + i);
                end
            CMD_READ:
                if (r >= 0 && r < ROWS)
                    o.bits = shadow_rows[r];
                else
                    o.flag = 1'b1;
            default:
                o.flag = 1'b1;
        endcase
    endtask

    function automatic draw_cmd_t make_cmd(logic [CMD_W-1:0] op, int c, int r, int w, int h,
                                           int ec, int er, int rad);
        draw_cmd_t t;
        t.op   = op;
        t.c    = COORD_W'(c);
        t.r    = COORD_W'(r);
        t.w    = EXT_W'(w);
        t.h    = EXT_W'(h);
        t.ec   = COORD_W'(ec);
        t.er   = COORD_W'(er);
        t.rad  = EXT_W'(rad);
        t.idle = $urandom_range(0, 10);
        return t;
    endfunction

    function automatic logic signed [COORD_W-1:0] pick_coord(int lo, int hi);
        if ($urandom_range(0, 4) == 0)
            return COORD_W'($urandom);
        return COORD_W'(lo + int'($urandom_range(0, hi - lo)));
    endfunction

    function automatic logic [EXT_W-1:0] pick_extent(int hi);
        if ($urandom_range(0, 5) == 0)
            return EXT_W'($urandom);
        return EXT_W'($urandom_range(0, hi));
    endfunction

    function automatic draw_cmd_t random_cmd(int n);
        draw_cmd_t t;
        int unsigned sel;
        int unsigned kind;
        t = make_cmd(CMD_UNKNOWN, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom);
        sel = $urandom_range(0, 99);
        if (sel < 3)
            t.op = CMD_CLEAR;
        else if (sel < 22)
            t.op = CMD_FILL;
        else if (sel < 34)
            t.op = CMD_ERASE;
        else if (sel < 52)
            t.op = CMD_LINE;
        else if (sel < 60)
            t.op = CMD_DISK;
        else if (sel < 70)
            t.op = CMD_TRI;
        else if (sel < 97)
            t.op = CMD_READ;
        case (t.op)
            CMD_FILL, CMD_ERASE:
            begin
                t.c = pick_coord(-12, COLS + 4);
                t.r = pick_coord(-6, ROWS + 2);
                t.w = pick_extent(40);
                t.h = pick_extent(16);
            end
            CMD_LINE:
            begin
                t.c  = pick_coord(-8, COLS + 4);
                t.r  = pick_coord(-4, ROWS + 2);
                kind = $urandom_range(0, 9);
                t.ec = pick_coord(-8, COLS + 4);
                t.er = pick_coord(-4, ROWS + 2);
                if (kind < 5)
                    t.er = t.r;
                else if (kind < 8)
                    t.ec = t.c;
            end
            CMD_DISK:
            begin
                t.c   = pick_coord(-10, COLS + 8);
                t.r   = pick_coord(-10, ROWS + 8);
                t.rad = ($urandom_range(0, 9) == 0) ? EXT_W'($urandom) :
                                                      EXT_W'($urandom_range(0, 12));
            end
            CMD_TRI:
            begin
                t.c = pick_coord(-10, COLS + 2);
                t.r = pick_coord(-10, ROWS + 2);
                t.w = pick_extent(30);
            end
            CMD_READ:
                t.r = pick_coord(-4, ROWS + 3);
            default:
                ;
        endcase
        t.idle = (((n / 250) % 3) == 0) ? 0 : $urandom_range(0, 10);
        return t;
    endfunction

    always @(posedge clk)
    begin : watch_ports
        draw_cmd_t  took;
        row_reply_t want;
        row_reply_t got_none;
        if (!rst_n)
        begin
            cmd_fire <= 1'b0;
            res_fire <= 1'b0;
        end
        else
        begin
            res_fire <= res_valid && !res_stall;
            cmd_fire <= cmd_valid && !cmd_stall;
            if (res_valid && !res_stall)
            begin
                replies_seen++;
                if (status)
                    flagged_seen++;
                if (expected_replies.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("%0t: unexpected transaction bits %h status %b",
                                 $time, row_bits, status);
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (row_bits !== want.bits || status !== want.flag)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_SHOWN)
                            $display("%0t: command %0d expected bits %h status %b, got bits %h status %b",
                                     $time, want.op, want.bits, want.flag, row_bits, status);
                    end
                end
            end
            if (cmd_valid && !cmd_stall)
            begin
                took.op   = command;
                took.c    = col;
                took.r    = row;
                took.w    = extent_w;
                took.h    = extent_h;
                took.ec   = end_col;
                took.er   = end_row;
                took.rad  = radius;
                took.idle = 0;
                render_command(took, got_none);
                expected_replies.push_back(got_none);
            end
        end
    end

    always @(negedge clk)
    begin : drive_commands
        draw_cmd_t nxt;
        logic      offer;
        offer = cmd_valid;
        if (cmd_fire)
        begin
            offer = 1'b0;
            if (pending_cmds.size() != 0)
                cmd_idle = pending_cmds[0].idle;
        end
        if (rst_n && !offer)
        begin
            if (cmd_idle > 0)
                cmd_idle--;
            else if (pending_cmds.size() != 0)
            begin
                nxt = pending_cmds.pop_front();
                command  <= nxt.op;
                col      <= nxt.c;
                row      <= nxt.r;
                extent_w <= nxt.w;
                extent_h <= nxt.h;
                end_col  <= nxt.ec;
                end_row  <= nxt.er;
                radius   <= nxt.rad;
                offer = 1'b1;
            end
        end
        cmd_valid <= offer;
    end

    always @(negedge clk)
    begin : drive_stall
        logic hold;
        if (res_fire)
            res_idle = (((replies_seen / 200) % 3) == 0) ? 0 : $urandom_range(0, 10);
        hold = hold_off || (res_idle > 0);
        if (res_idle > 0)
            res_idle--;
        res_stall <= rst_n && hold;
    end

    initial
    begin : hold_results
        while (replies_seen < 300)
            @(posedge clk);
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
    end

    initial
    begin : run_limit
        #(20_000_000);
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin : stimulus
        rst_n     = 1'b0;
        cmd_valid = 1'b0;
        res_stall = 1'b0;
        hold_off  = 1'b0;
        cmd_fire  = 1'b0;
        res_fire  = 1'b0;
        command   = CMD_CLEAR;
        col       = '0;
        row       = '0;
        extent_w  = '0;
        extent_h  = '0;
        end_col   = '0;
        end_row   = '0;
        radius    = '0;
        cmd_idle  = 0;
        res_idle  = 0;
        replies_seen = 0;
        flagged_seen = 0;
        mismatches   = 0;
        for (int i = 0; i < 8; i++)
            op_count[i] = 0;
        for (int i = 0; i < ROWS; i++)
            shadow_rows[i] = '0;

        pending_cmds.push_back(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_FILL, -5, -3, 20, 10, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_FILL, 60, 30, 127, 127, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_READ, 0, 31, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_FILL, 5, 5, 0, 10, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_FILL, 5, 5, 10, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_ERASE, -128, -128, 127, 127, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_ERASE, 2, 0, 5, 127, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_READ, 0, 5, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_LINE, -10, 7, 0, 0, 100, 7, 0));
        pending_cmds.push_back(make_cmd(CMD_LINE, 20, 8, 0, 0, 10, 8, 0));
        pending_cmds.push_back(make_cmd(CMD_LINE, 63, 9, 0, 0, 63, 9, 0));
        pending_cmds.push_back(make_cmd(CMD_LINE, 40, -5, 0, 0, 40, 127, 0));
        pending_cmds.push_back(make_cmd(CMD_LINE, 41, 20, 0, 0, 41, 3, 0));
        pending_cmds.push_back(make_cmd(CMD_LINE, 1, 1, 0, 0, 5, 5, 0));
        pending_cmds.push_back(make_cmd(CMD_TRI, -2, -2, 10, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_TRI, 127, 127, 127, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_TRI, 3, 3, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_READ, 0, 3, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_DISK, -128, 127, 0, 0, 0, 0, 127));
        pending_cmds.push_back(make_cmd(CMD_DISK, 0, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_READ, 0, -1, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_READ, 0, 32, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_READ, 0, 127, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_READ, 0, -128, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_UNKNOWN, 0, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_DISK, 32, 16, 0, 0, 0, 0, 127));
        pending_cmds.push_back(make_cmd(CMD_READ, 0, 20, 0, 0, 0, 0, 0));
        for (int n = 0; n < N_RANDOM; n++)
            pending_cmds.push_back(random_cmd(n));

        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        while (pending_cmds.size() != 0 || cmd_valid)
            @(posedge clk);
        while (expected_replies.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d commands: clear %0d, fill %0d, erase %0d, line %0d, disk %0d,",
                 replies_seen, op_count[CMD_CLEAR], op_count[CMD_FILL], op_count[CMD_ERASE],
                 op_count[CMD_LINE], op_count[CMD_DISK]);
        $display("  triangle %0d, read %0d, unknown %0d; %0d error replies, %0d mismatches",
                 op_count[CMD_TRI], op_count[CMD_READ], op_count[CMD_UNKNOWN],
                 flagged_seen, mismatches);
        if (mismatches == 0 && expected_replies.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[raster_primitive_fill_engine_top.f]
src/rpfe_pkg.sv
src/rpfe_ram.sv
src/rpfe_mask.sv
src/raster_primitive_fill_engine_top.sv
test/raster_primitive_fill_engine_top_test.sv
